>>> sv/mppm_pkg.sv
// Package: widths, register indexes, reset values and the binomial table.
package mppm_pkg;

    localparam int MAX_SLOTS  = 16;
    localparam int MAX_HEADER = 8;

    // field and register widths
    localparam int SYM_W      = 14;
    localparam int SLOTS_W    = 5;
    localparam int PULSES_W   = 5;
    localparam int HPAT_W     = 8;
    localparam int HLEN_W     = 4;
    localparam int FRAME_W    = 24;
    localparam int FLEN_W     = 5;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 32;

    // derived widths
    localparam int NW     = $clog2(MAX_SLOTS + 1);
    localparam int HW     = (MAX_HEADER < 1) ? 1 : $clog2(MAX_HEADER + 1);
    localparam int BW     = SYM_W + 1;               // binomial, saturated at 2**SYM_W
    localparam int SUM_W  = NW + HW + 1;
    localparam int WIDE_W = (MAX_SLOTS + MAX_HEADER + HPAT_W > FRAME_W) ?
                            (MAX_SLOTS + MAX_HEADER + HPAT_W) : FRAME_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOTS_USED     = 2'd0,
        REG_PULSES         = 2'd1,
        REG_HEADER_PATTERN = 2'd2,
        REG_HEADER_LENGTH  = 2'd3
    } cfg_reg_t;

    localparam logic [SLOTS_W-1:0]  RST_SLOTS_USED     = 5'd6;
    localparam logic [PULSES_W-1:0] RST_PULSES         = 5'd4;
    localparam logic [HPAT_W-1:0]   RST_HEADER_PATTERN = 8'd17;
    localparam logic [HLEN_W-1:0]   RST_HEADER_LENGTH  = 4'd5;

    // one item in flight
    typedef struct packed {
        logic [SYM_W-1:0]     rem;
        logic [NW-1:0]        pulses_left;
        logic [NW-1:0]        n;
        logic [HW-1:0]        h;
        logic [HPAT_W-1:0]    hdr;
        logic                 invalid;
        logic [MAX_SLOTS-1:0] code;
    } pipe_t;

    typedef logic [MAX_SLOTS:0][MAX_SLOTS:0][BW-1:0] binom_tbl_t;

    // Pascal's triangle, entries clamped to 2**SYM_W (only compared against symbols)
    function automatic binom_tbl_t build_binom();
        binom_tbl_t t;
        int         v;
        t = '0;
        for (int r = 0; r <= MAX_SLOTS; r++) begin
            t[r][0] = BW'(1);
            for (int c = 1; c <= r; c++) begin
                v = int'(t[r-1][c-1]) + int'(t[r-1][c]);
                if (v > (1 << SYM_W)) begin
                    v = 1 << SYM_W;
                end
                t[r][c] = BW'(v);
            end
        end
        return t;
    endfunction

    localparam binom_tbl_t BINOM = build_binom();

endpackage

>>> sv/mppm_frame_encoder.sv
// Multi-pulse PPM frame encoder: one symbol in, one header + codeword frame out.
//
//  Channel | Dir | Beat contents (low bit first)                     | Handshake
//  --------+-----+---------------------------------------------------+------------------
//  s_*     | in  | tdata: symbol[13:0], zero pad                     | tvalid/tready
//  m_*     | out | tdata: frame_slots[23:0], frame_length[28:24]     | tvalid/tready
//          |     | tuser: symbol_invalid                             |
//  cfg_*   | in  | cfg_index selects register, cfg_data is the value | cfg_we, no wait
//
// One beat per cycle in and out while m_tready is high. The pipeline is an input
// stage (clamping and range check), one stage per codeword slot, and the
// output register.
// Reset clears all valid bits and loads the default configuration.
// Each stage has its own ready, so a stall on m_tready backs up stage by
// stage and bubbles close up; nothing is dropped or repeated.
module mppm_frame_encoder
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mppm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mppm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mppm_pkg::S_TDATA_W-1:0]       s_tdata,   // symbol[13:0]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mppm_pkg::M_TDATA_W-1:0]       m_tdata,   // frame_slots, frame_length
    output logic                                 m_tuser    // symbol_invalid
);
    import mppm_pkg::*;

    localparam int S = MAX_SLOTS;

    // configuration registers
    logic [SLOTS_W-1:0]  slots_used_reg;
    logic [PULSES_W-1:0] pulses_reg;
    logic [HPAT_W-1:0]   header_pattern_reg;
    logic [HLEN_W-1:0]   header_length_reg;

    // pipeline: stage 0 = input stage, stage k = after codeword slot S-k
    logic  valid_reg [0:S];
    pipe_t pipe_reg  [0:S];
    pipe_t pipe_next [0:S];
    logic  rdy       [0:S+1];

    // output register
    logic               out_valid_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [FRAME_W-1:0] frame_next;
    logic [FLEN_W-1:0]  flen_reg;
    logic [FLEN_W-1:0]  flen_next;
    logic               inv_reg;

    // stage 0 helpers
    logic [NW-1:0]     n_in;
    logic [NW-1:0]     p_in;
    logic              p_ok;
    logic [HW-1:0]     h_in;
    logic [HPAT_W-1:0] hdr_in;
    logic [BW-1:0]     limit;
    logic              inv_in;

    logic [WIDE_W-1:0] wide_frame;

    // ---------------- configuration write port ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_used_reg     <= RST_SLOTS_USED;
            pulses_reg         <= RST_PULSES;
            header_pattern_reg <= RST_HEADER_PATTERN;
            header_length_reg  <= RST_HEADER_LENGTH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SLOTS_USED:     slots_used_reg     <= cfg_data[SLOTS_W-1:0];
                REG_PULSES:         pulses_reg         <= cfg_data[PULSES_W-1:0];
                REG_HEADER_PATTERN: header_pattern_reg <= cfg_data[HPAT_W-1:0];
                REG_HEADER_LENGTH:  header_length_reg  <= cfg_data[HLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- ready chain ----------------
    always_comb
    begin
        rdy[S+1] = !out_valid_reg || m_tready;
        for (int k = S; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[0];

    // ---------------- stage 0: clamp config, range check ----------------
    always_comb
    begin
        // slot count: 0 acts as 1, capped at MAX_SLOTS
        if (int'(slots_used_reg) == 0)
        begin
            n_in = NW'(1);
        end
        else if (int'(slots_used_reg) > S)
        begin
            n_in = NW'(S);
        end
        else
        begin
            n_in = NW'(slots_used_reg);
        end

        p_ok = (int'(pulses_reg) <= S);
        p_in = p_ok ? NW'(pulses_reg) : '0;

        if (int'(header_length_reg) > MAX_HEADER)
        begin
            h_in = HW'(MAX_HEADER);
        end
        else
        begin
            h_in = HW'(header_length_reg);
        end

        for (int j = 0; j < HPAT_W; j++)
        begin
            hdr_in[j] = header_pattern_reg[j] && (j < int'(h_in));
        end

        // C(n, p) is 0 when p > n, so such symbols always come out invalid
        limit  = BINOM[n_in][p_in];
        inv_in = !p_ok || ({1'b0, s_tdata[SYM_W-1:0]} >= limit);

        pipe_next[0].rem         = s_tdata[SYM_W-1:0];
        pipe_next[0].pulses_left = p_in;
        pipe_next[0].n           = n_in;
        pipe_next[0].h           = h_in;
        pipe_next[0].hdr         = hdr_in;
        pipe_next[0].invalid     = inv_in;
        pipe_next[0].code        = '0;
    end

    // ---------------- slot stages, highest slot first ----------------
    for (genvar k = 1; k <= S; k++)
    begin : g_slot
        localparam int SLOT = S - k;

        logic          active;
        logic          fill;     // pulses left cover every remaining slot
        logic [NW-1:0] p_sel;
        logic [BW-1:0] y;
        logic          take;

        always_comb
        begin
            pipe_next[k] = pipe_reg[k-1];

            active = !pipe_reg[k-1].invalid && (SLOT < int'(pipe_reg[k-1].n))
                     && (pipe_reg[k-1].pulses_left != '0);
            fill   = (int'(pipe_reg[k-1].pulses_left) > SLOT);
            p_sel  = fill ? '0 : pipe_reg[k-1].pulses_left;
            y      = BINOM[SLOT][p_sel];
            take   = !fill && ({1'b0, pipe_reg[k-1].rem} >= y);

            if (active && (fill || take))
            begin
                pipe_next[k].code[SLOT]  = 1'b1;
                pipe_next[k].pulses_left = pipe_reg[k-1].pulses_left - NW'(1);
            end
            if (active && take)
            begin
                pipe_next[k].rem = pipe_reg[k-1].rem - y[SYM_W-1:0];
            end
        end
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= S; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k <= S; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (rdy[S+1])
            begin
                out_valid_reg <= valid_reg[S];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && s_tvalid)
        begin
            pipe_reg[0] <= pipe_next[0];
        end
        for (int k = 1; k <= S; k++)
        begin
            if (rdy[k] && valid_reg[k-1])
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
        if (rdy[S+1] && valid_reg[S])
        begin
            frame_reg <= frame_next;
            flen_reg  <= flen_next;
            inv_reg   <= pipe_reg[S].invalid;
        end
    end

    // ---------------- frame assembly ----------------
    always_comb
    begin
        wide_frame = WIDE_W'(pipe_reg[S].hdr)
                   | (WIDE_W'(pipe_reg[S].code) << pipe_reg[S].h);
        frame_next = wide_frame[FRAME_W-1:0];
        flen_next  = FLEN_W'(SUM_W'(pipe_reg[S].h) + SUM_W'(pipe_reg[S].n));
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({flen_reg, frame_reg});
    assign m_tuser  = inv_reg;

`ifndef SYNTHESIS
    // an invalid symbol never places a pulse
    a_invalid_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[S] && pipe_reg[S].invalid) |-> (pipe_reg[S].code == '0))
        else $error("pulse placed for invalid symbol");

    // a valid symbol places every pulse
    a_all_pulses_placed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[S] && !pipe_reg[S].invalid) |-> (pipe_reg[S].pulses_left == '0))
        else $error("pulses left over at end of codeword");

    // a valid symbol is fully consumed by the slot walk
    a_remainder_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[S] && !pipe_reg[S].invalid) |-> (pipe_reg[S].rem == '0))
        else $error("symbol remainder not zero at end of codeword");
`endif

endmodule

>>> tb/tb_mppm_frame_encoder.sv
// Self-checking testbench for the multi-pulse PPM frame encoder.
`timescale 1ns / 100ps

module tb_mppm_frame_encoder;

    import mppm_pkg::*;

    // pipeline depth from the block header: input stage, one per slot, output reg
    localparam int LAT         = MAX_SLOTS + 2;
    localparam int CYCLE_LIMIT = 500000;
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 125;
    localparam int MAX_GAP     = 17;
    localparam int LONG_HOLD   = 400;

    // one frame as seen on the master side
    typedef struct {
        logic [FRAME_W-1:0] slots;
        logic [FLEN_W-1:0]  length;
        logic               invalid;
    } frame_t;

    // directed stimulus row: register values, symbol, optional typed-in frame
    typedef struct {
        logic [7:0]         slots;
        logic [7:0]         pulses;
        logic [7:0]         hpat;
        logic [7:0]         hlen;
        logic [SYM_W-1:0]   sym;
        bit                 typed;
        logic [FRAME_W-1:0] frame;
        logic [FLEN_W-1:0]  len;
        logic               inv;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;     // symbol[13:0], zero pad
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;     // frame_slots[23:0], frame_length[28:24]
    logic                  m_tuser;     // symbol_invalid

    // shadow copies of the registers, at register width
    logic [SLOTS_W-1:0]  slots_reg;
    logic [PULSES_W-1:0] pulses_reg;
    logic [HPAT_W-1:0]   hpat_reg;
    logic [HLEN_W-1:0]   hlen_reg;
    // raw bytes last written, to spot a config change in the table
    logic [7:0]          cur_cfg [4];

    frame_t    frames_due [$];
    dir_row_t  dir_rows [$];
    int        mismatches;
    int        cycle_cnt;
    bit        idle_on;
    int        hold_len;

    mppm_frame_encoder i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // watchdog
    initial cycle_cnt = 0;
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // n choose k, 0 when k > n; every partial product is itself a binomial
    function automatic longint unsigned choose(input int n, input int k);
        longint unsigned acc;
        acc = 1;
        if (k > n)
        begin
            return 0;
        end
        for (int i = 1; i <= k; i++)
        begin
            acc = acc * longint'(n - k + i) / longint'(i);
        end
        return acc;
    endfunction

    // slot count after clamping to 1..MAX_SLOTS
    function automatic int eff_slots();
        int n;
        n = int'(slots_reg);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > MAX_SLOTS)
        begin
            n = MAX_SLOTS;
        end
        return n;
    endfunction

    // number of valid symbols under the current setting
    function automatic longint unsigned symbol_limit();
        return choose(eff_slots(), int'(pulses_reg));
    endfunction

    function automatic frame_t mppm_encode(input logic [SYM_W-1:0] sym);
        frame_t          r;
        int              n;
        int              h;
        int              p;
        longint unsigned rem;
        longint unsigned y;
        logic [31:0]     code;
        logic [31:0]     frame;
        logic            take;
        n    = eff_slots();
        p    = int'(pulses_reg);
        h    = (int'(hlen_reg) > MAX_HEADER) ? MAX_HEADER : int'(hlen_reg);
        rem  = longint'(sym);
        code = '0;
        r.invalid = (rem >= symbol_limit());
        // walk slots high to low, greedy on C(slots_left-1, pulses_left)
        if (!r.invalid)
        begin
            for (int s = n; s > 0; s--)
            begin
                if (p == 0)
                begin
                    take = 1'b0;        // no pulses left: rest stays dark
                end
                else if (p >= s)
                begin
                    take = 1'b1;        // must fill every remaining slot
                end
                else
                begin
                    y    = choose(s - 1, p);
                    take = (y <= rem);
                    if (take)
                    begin
                        rem = rem - y;
                    end
                end
                if (take)
                begin
                    code[s-1] = 1'b1;
                    p--;
                end
            end
        end
        frame    = (32'(hpat_reg) & ((32'd1 << h) - 32'd1)) | (code << h);
        r.slots  = frame[FRAME_W-1:0];
        r.length = FLEN_W'(h + n);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    function automatic void add_row(input logic [7:0] slots, input logic [7:0] pulses,
                                    input logic [7:0] hpat, input logic [7:0] hlen,
                                    input logic [SYM_W-1:0] sym, input bit typed,
                                    input logic [FRAME_W-1:0] frame,
                                    input logic [FLEN_W-1:0] len, input logic inv);
        dir_row_t r;
        r.slots  = slots;
        r.pulses = pulses;
        r.hpat   = hpat;
        r.hlen   = hlen;
        r.sym    = sym;
        r.typed  = typed;
        r.frame  = frame;
        r.len    = len;
        r.inv    = inv;
        dir_rows.push_back(r);
    endfunction

    // offer one symbol after an optional gap; returns at the accepting edge.
    // With no gap, tvalid simply stays high into the next beat.
    task automatic send_symbol(input logic [SYM_W-1:0] sym, input frame_t exp_frame);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - SYM_W){1'b0}}, sym};
        frames_due.push_back(exp_frame);
        do @(posedge clk); while (!s_tready);
    endtask

    // stop offering and let the pipeline empty out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(posedge clk);
        repeat (LAT) @(posedge clk);
    endtask

    // all four registers on back-to-back cycles, only with the block drained
    task automatic load_config(input logic [7:0] slots, input logic [7:0] pulses,
                               input logic [7:0] hpat, input logic [7:0] hlen);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_SLOTS_USED;
        cfg_data  <= slots;
        @(posedge clk);
        cfg_index <= REG_PULSES;
        cfg_data  <= pulses;
        @(posedge clk);
        cfg_index <= REG_HEADER_PATTERN;
        cfg_data  <= hpat;
        @(posedge clk);
        cfg_index <= REG_HEADER_LENGTH;
        cfg_data  <= hlen;
        @(posedge clk);
        cfg_we     <= 1'b0;
        slots_reg  = slots[SLOTS_W-1:0];
        pulses_reg = pulses[PULSES_W-1:0];
        hpat_reg   = hpat[HPAT_W-1:0];
        hlen_reg   = hlen[HLEN_W-1:0];
        cur_cfg    = '{slots, pulses, hpat, hlen};
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_len > 0)
            begin
                stall    = hold_len;
                hold_len = 0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // Checker: each accepted beat against the oldest pending frame
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        frame_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frames_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: unexpected beat tdata=%h tuser=%b", m_tdata, m_tuser);
                end
            end
            else
            begin
                want = frames_due.pop_front();
                if (m_tdata[FRAME_W-1:0] !== want.slots ||
                    m_tdata[FRAME_W +: FLEN_W] !== want.length ||
                    m_tuser !== want.invalid)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: slots %h/%h length %0d/%0d invalid %b/%b (exp/act)",
                                 want.slots, m_tdata[FRAME_W-1:0],
                                 want.length, m_tdata[FRAME_W +: FLEN_W],
                                 want.invalid, m_tuser);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        frame_t          f;
        longint unsigned lim;
        logic [7:0]      ps;
        logic [7:0]      pp;
        logic [7:0]      ph;
        logic [7:0]      pl;
        logic [SYM_W-1:0] sym;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_SLOTS_USED;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        mismatches = 0;
        hold_len   = 0;
        idle_on    = 1'b1;
        slots_reg  = RST_SLOTS_USED;
        pulses_reg = RST_PULSES;
        hpat_reg   = RST_HEADER_PATTERN;
        hlen_reg   = RST_HEADER_LENGTH;
        cur_cfg    = '{8'(RST_SLOTS_USED), 8'(RST_PULSES),
                       8'(RST_HEADER_PATTERN), 8'(RST_HEADER_LENGTH)};

        // reset setting: 6 slots, 4 pulses, header 1,0,0,0,1
        add_row(6, 4, 17, 5, 0,     1, 24'h0001F1, 11, 0);  // lowest codeword
        add_row(6, 4, 17, 5, 14,    1, 24'h000791, 11, 0);  // highest codeword
        add_row(6, 4, 17, 5, 15,    1, 24'h000011, 11, 1);  // first invalid
        add_row(6, 4, 17, 5, 16383, 1, 24'h000011, 11, 1);
        add_row(6, 4, 17, 5, 7,     0, '0, '0, 0);
        // widest frame, largest C(n,r)
        add_row(16, 8, 8'hFF, 8, 0,       1, 24'h00FFFF, 24, 0);
        add_row(16, 8, 8'hFF, 8, 12869,   1, 24'hFF00FF, 24, 0);
        add_row(16, 8, 8'hFF, 8, 12870,   1, 24'h0000FF, 24, 1);
        add_row(16, 8, 8'hFF, 8, 16383,   1, 24'h0000FF, 24, 1);
        add_row(16, 8, 8'hFF, 8, 14'h2AAA, 0, '0, '0, 0);
        add_row(16, 8, 8'hFF, 8, 14'h1555, 0, '0, '0, 0);
        // zero slots taken as one, no pulses, no header
        add_row(0, 0, 8'h00, 0, 0, 1, 24'h000000, 1, 0);
        add_row(0, 0, 8'h00, 0, 1, 1, 24'h000000, 1, 1);
        // slot count clamped to 16, every slot lit, header clamped to 8
        add_row(31, 16, 8'hA5, 15, 0, 1, 24'hFFFFA5, 24, 0);
        add_row(31, 16, 8'hA5, 15, 1, 1, 24'h0000A5, 24, 1);
        // more pulses than slots: nothing is valid
        add_row(4, 5, 8'h5A, 3, 0, 1, 24'h000002, 7, 1);
        // upper config bits set, must be dropped: 8 slots, 3 pulses, 4 header
        add_row(8'hE8, 8'hE3, 8'h3C, 8'hF4, 0,  1, 24'h00007C, 12, 0);
        add_row(8'hE8, 8'hE3, 8'h3C, 8'hF4, 55, 1, 24'h000E0C, 12, 0);
        add_row(8'hE8, 8'hE3, 8'h3C, 8'hF4, 20, 0, '0, '0, 0);
        // single slot, single pulse
        add_row(1, 1, 8'h01, 1, 0,      1, 24'h000003, 2, 0);
        add_row(1, 1, 8'h01, 1, 14'h3FFF, 1, 24'h000001, 2, 1);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].slots !== cur_cfg[0] || dir_rows[i].pulses !== cur_cfg[1] ||
                dir_rows[i].hpat !== cur_cfg[2] || dir_rows[i].hlen !== cur_cfg[3])
            begin
                load_config(dir_rows[i].slots, dir_rows[i].pulses,
                            dir_rows[i].hpat, dir_rows[i].hlen);
            end
            if (dir_rows[i].typed)
            begin
                f.slots   = dir_rows[i].frame;
                f.length  = dir_rows[i].len;
                f.invalid = dir_rows[i].inv;
            end
            else
            begin
                f = mppm_encode(dir_rows[i].sym);
            end
            send_symbol(dir_rows[i].sym, f);
        end

        // random phases, each with its own setting
        for (int k = 0; k < N_PHASES; k++)
        begin
            ph = 8'($urandom);
            if (k == 0)
            begin
                ps = 16;
                pp = 8;
                pl = 8;
            end
            else if (k == 1)
            begin
                ps = 1;
                pp = 8'($urandom_range(0, 1));
                pl = 0;
            end
            else if (k == N_PHASES - 1)
            begin
                ps = 16;
                pp = 16;
                pl = 8;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                // anything goes: clamping, excess pulses, long header
                ps = 8'($urandom);
                pp = 8'($urandom);
                pl = 8'($urandom);
            end
            else
            begin
                ps = 8'($urandom_range(1, MAX_SLOTS));
                pp = 8'($urandom_range(0, ps));
                pl = 8'($urandom_range(0, MAX_HEADER));
            end
            load_config(ps, pp, ph, pl);

            // phase 2: receiver holds off long while the sender streams flat out
            if (k == 2)
            begin
                idle_on  = 1'b0;
                hold_len = LONG_HOLD;
            end
            else
            begin
                idle_on = ($urandom_range(0, 3) != 0);
            end

            lim = symbol_limit();
            for (int j = 0; j < PHASE_ITEMS; j++)
            begin
                // mostly valid symbols, the rest over the full 14-bit range
                if (lim > 0 && $urandom_range(0, 3) != 0)
                begin
                    sym = SYM_W'($urandom_range(0, int'(lim) - 1));
                end
                else
                begin
                    sym = SYM_W'($urandom);
                end
                send_symbol(sym, mppm_encode(sym));
            end
        end

        idle_on = 1'b1;
        wait_idle();
        if (mismatches == 0 && frames_due.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/mppm_pkg.sv
sv/mppm_frame_encoder.sv
tb/tb_mppm_frame_encoder.sv
